/* src/mtcg_pkg.sv */
`default_nettype none
package mtcg_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN      = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_TONES = CFG_INDEX_BITS'(1);

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // quarter-wave sine polynomial, Q15 coefficients
  localparam logic [15:0] SIN_A   = 16'd51472;
  localparam logic [14:0] SIN_B   = 15'd21024;
  localparam logic [11:0] SIN_C   = 12'd2320;
  localparam logic [14:0] QUARTER = 15'd16384;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_LOAD,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  idx;
    logic [15:0] step;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_SCALE,
    ST_ROUND,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

/* src/multi_tone_cosine_generator.sv */
`default_nettype none
// channel   direction  handshake                 payload
// input     in         push / full               func, tone_index, tone_bin
// result    out        empty / pop               sample
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// a load is written to the tone table in the same cycle that it leaves the two-entry command queue
// a tick reads num_tones (at most MAX_TONES) tone table entries, or goes straight to scale with none:
// one tone table read per cycle feeds the shared five-stage cosine pipeline, then
// the sequencer waits for the pipeline to drain, then scale, round and emit
// rst is synchronous and clears the tone table valid bits, config registers, sequencer state and queues
// results wait in a two-entry queue; a full queue holds the sequencer in emit
module multi_tone_cosine_generator #(
  parameter int MAX_TONES   = 16,
  parameter int PHASE_BITS  = 15,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic                                func,
  input  wire logic [3:0]                          tone_index,
  input  wire logic [14:0]                         tone_bin,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic signed [SAMPLE_BITS-1:0]            sample,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mtcg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [mtcg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import mtcg_pkg::*;

  cmd_t                   cmd;
  logic                   cmd_empty;
  logic                   cmd_pop;
  logic                   res_full;
  logic                   res_push;
  logic [SAMPLE_BITS-1:0] res_data;
  logic [SAMPLE_BITS-1:0] res_out;

  assign cfg_ready = 1'b1;

  mtcg_front #(
    .MAX_TONES  (MAX_TONES),
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .tone_index (tone_index),
    .tone_bin   (tone_bin),
    .cmd_pop    (cmd_pop),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd)
  );

  mtcg_back #(
    .MAX_TONES   (MAX_TONES),
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  mtcg_fifo #(
    .WIDTH (SAMPLE_BITS),
    .AW    (1)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_data),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign sample = $signed(res_out);

endmodule
`default_nettype wire

/* src/mtcg_fifo.sv */
`default_nettype none
module mtcg_fifo #(
  parameter int WIDTH = 8,
  parameter int AW    = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [2**AW];
  logic [AW:0]      wr_ptr;
  logic [AW:0]      rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (wr_ptr == rd_ptr);
  assign full    = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + (AW+1)'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr[AW-1:0]] <= din;
    end
  end

endmodule
`default_nettype wire

/* src/mtcg_front.sv */
`default_nettype none
module mtcg_front #(
  parameter int MAX_TONES  = 16,
  parameter int PHASE_BITS = 15
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic          func,
  input  wire logic [3:0]    tone_index,
  input  wire logic [14:0]   tone_bin,
  input  wire logic          cmd_pop,
  output logic               cmd_empty,
  output mtcg_pkg::cmd_t     cmd
);
  import mtcg_pkg::*;

  localparam int HALF = 1 << (PHASE_BITS - 1);

  cmd_t                 cmd_in;
  logic [16:0]          bin_ext;
  logic [16:0]          bin_clamped;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  assign bin_ext     = 17'(tone_bin);
  assign bin_clamped = (bin_ext > 17'(HALF)) ? 17'(HALF) : bin_ext;

  always_comb begin
    cmd_in.idx  = tone_index;
    cmd_in.step = bin_clamped[15:0];
    if (func == FUNC_LOAD) begin
      cmd_in.kind = (7'(tone_index) < 7'(MAX_TONES)) ? CMD_LOAD : CMD_NOP;
    end else begin
      cmd_in.kind = CMD_TICK;
    end
  end

  mtcg_fifo #(
    .WIDTH ($bits(cmd_t)),
    .AW    (1)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd = cmd_t'(cmd_bits);

endmodule
`default_nettype wire

/* src/mtcg_cos.sv */
`default_nettype none
module mtcg_cos #(
  parameter int PHASE_BITS = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [PHASE_BITS-1:0] phase,
  output logic                       out_valid,
  output logic signed [15:0]         cosine,
  output logic                       busy
);
  import mtcg_pkg::*;

  logic [4:0]  v;

  logic [15:0] ang;
  logic [1:0]  quad;
  logic [14:0] f;
  logic [14:0] x_in;

  logic [14:0] x_a;
  logic        neg_a;

  logic [29:0] sq;
  logic [14:0] x_b;
  logic [14:0] x2_b;
  logic        neg_b;

  logic [26:0] pc;
  logic [12:0] t1_c;
  logic [14:0] x_c;
  logic [14:0] x2_c;
  logic        neg_c;

  logic [14:0] tb;
  logic [29:0] pd;
  logic [15:0] u_d;
  logic [14:0] x_d;
  logic        neg_d;

  logic [15:0] ta;
  logic [30:0] pe;
  logic [16:0] m;
  logic [15:0] mag;

  assign ang  = 16'(phase) << (16 - PHASE_BITS);
  assign quad = ang[15:14];
  assign f    = {1'b0, ang[13:0]};
  assign x_in = quad[0] ? f : (QUARTER - f);

  assign sq = 30'(x_a) * 30'(x_a);
  assign pc = 27'(SIN_C) * 27'(x2_b);
  assign tb = SIN_B - 15'(t1_c);
  assign pd = 30'(tb) * 30'(x2_c);
  assign ta = SIN_A - u_d;
  assign pe = 31'(ta) * 31'(x_d);
  assign m  = pe[30:14];
  assign mag = (m > 17'd32767) ? 16'h7FFF : {1'b0, m[14:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    x_a   <= x_in;
    neg_a <= quad[0] ^ quad[1];

    x_b   <= x_a;
    x2_b  <= sq[28:14];
    neg_b <= neg_a;

    t1_c  <= pc[26:14];
    x_c   <= x_b;
    x2_c  <= x2_b;
    neg_c <= neg_b;

    u_d   <= pd[29:14];
    x_d   <= x_c;
    neg_d <= neg_c;

    cosine <= neg_d ? -$signed(mag) : $signed(mag);
  end

  assign out_valid = v[4];
  assign busy      = |v;

endmodule
`default_nettype wire

/* src/mtcg_back.sv */
`default_nettype none
module mtcg_back #(
  parameter int MAX_TONES   = 16,
  parameter int PHASE_BITS  = 15,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cmd_empty,
  output logic                                     cmd_pop,
  input  wire mtcg_pkg::cmd_t                      cmd,
  input  wire logic                                cfg_valid,
  input  wire logic [mtcg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [mtcg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                res_full,
  output logic                                     res_push,
  output logic [SAMPLE_BITS-1:0]                   res_data
);
  import mtcg_pkg::*;

  localparam int TW  = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int CW  = $clog2(MAX_TONES + 1);
  localparam int SW  = 17 + $clog2(MAX_TONES);
  localparam int PW  = SW + 17;
  localparam int SH  = 32 - SAMPLE_BITS;
  localparam int LIM = (1 << (SAMPLE_BITS - 1)) - 1;

  localparam logic [PW:0]          HALF_LSB = (PW+1)'(1) << (SH - 1);
  localparam logic [PW:0]          LIM_V    = (PW+1)'(LIM);
  localparam logic [SAMPLE_BITS-1:0] SMAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  state_t state, state_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] n;

  logic [15:0] gain;
  logic [4:0]  num_tones;

  logic [2*PHASE_BITS-1:0] tone_mem [MAX_TONES];
  logic [MAX_TONES-1:0]    tone_valid;
  logic [2*PHASE_BITS-1:0] rd_data;
  logic [TW-1:0]           rd_addr_q;
  logic                    rd_ok;
  logic                    rd_v;
  logic                    rd_en;

  logic                    load_we;
  logic                    wb_we;
  logic                    mem_we;
  logic [TW-1:0]           mem_waddr;
  logic [2*PHASE_BITS-1:0] mem_wdata;
  logic [PHASE_BITS-1:0]   cur_step;
  logic [PHASE_BITS-1:0]   cur_phase;

  logic                    cos_v;
  logic signed [15:0]      cos_val;
  logic                    cos_busy;

  logic                    sum_clr;
  logic                    scale_en;
  logic                    round_en;
  logic signed [SW-1:0]    sum;
  logic signed [PW-1:0]    prod;
  logic [PW-1:0]           prod_mag;
  logic [PW:0]             rnd;
  logic                    neg;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= '0;
      num_tones <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN:      gain      <= cfg_data;
        REG_NUM_TONES: num_tones <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign n = (7'(num_tones) > 7'(MAX_TONES)) ? CW'(MAX_TONES) : CW'(num_tones);

  // tone table
  assign cur_step  = rd_ok ? rd_data[2*PHASE_BITS-1:PHASE_BITS] : '0;
  assign cur_phase = rd_ok ? rd_data[PHASE_BITS-1:0] : '0;
  assign wb_we     = rd_v && rd_ok;
  assign mem_we    = load_we || wb_we;
  assign mem_waddr = load_we ? TW'(cmd.idx) : rd_addr_q;
  assign mem_wdata = load_we ? {cmd.step[PHASE_BITS-1:0], {PHASE_BITS{1'b0}}}
                             : {cur_step, cur_phase + cur_step};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tone_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data   <= tone_mem[k[TW-1:0]];
      rd_addr_q <= k[TW-1:0];
      rd_ok     <= tone_valid[k[TW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_valid <= '0;
      rd_v       <= 1'b0;
    end else begin
      rd_v <= rd_en;
      if (load_we) begin
        tone_valid[TW'(cmd.idx)] <= 1'b1;
      end
    end
  end

  mtcg_cos #(
    .PHASE_BITS (PHASE_BITS)
  ) u_cos (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_v),
    .phase     (cur_phase),
    .out_valid (cos_v),
    .cosine    (cos_val),
    .busy      (cos_busy)
  );

  // accumulate, scale, round
  assign prod_mag = prod[PW-1] ? PW'(-prod) : PW'(prod);

  always_ff @(posedge clk) begin
    if (sum_clr) begin
      sum <= '0;
    end else if (cos_v) begin
      sum <= sum + SW'(cos_val);
    end
    if (scale_en) begin
      prod <= PW'(sum) * PW'($signed({1'b0, gain}));
    end
    if (round_en) begin
      neg <= prod[PW-1];
      rnd <= ({1'b0, prod_mag} + HALF_LSB) >> SH;
    end
  end

  always_comb begin
    if (neg) begin
      res_data = (rnd > LIM_V + (PW+1)'(1)) ? SMIN : -rnd[SAMPLE_BITS-1:0];
    end else begin
      res_data = (rnd > LIM_V) ? SMAX : rnd[SAMPLE_BITS-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    cmd_pop    = 1'b0;
    load_we    = 1'b0;
    rd_en      = 1'b0;
    sum_clr    = 1'b0;
    scale_en   = 1'b0;
    round_en   = 1'b0;
    res_push   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_LOAD: load_we = 1'b1;
            CMD_TICK: begin
              sum_clr    = 1'b1;
              k_next     = '0;
              state_next = (n == '0) ? ST_SCALE : ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        rd_en  = 1'b1;
        k_next = k + CW'(1);
        if (k == n - CW'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v && !cos_busy) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        scale_en   = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        round_en   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire
